// ----- sv/shfp_pkg.sv -----
// ----------------------------------------------------------------------------
// shfp_pkg
// Shared types for the sync-header frame parser.
// ----------------------------------------------------------------------------
package shfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int SEQ_W   = 16;
    localparam int COUNT_W = 32;

    // One completed frame as seen on the result channel
    typedef struct packed {
        logic [COUNT_W-1:0] bad_frames;
        logic [COUNT_W-1:0] good_frames;
        logic [SEQ_W-1:0]   frame_seq;
        logic               frame_status;
    } shfp_result_t;

endpackage

// ----- sv/sync_header_frame_parser.sv -----
// ----------------------------------------------------------------------------
// sync_header_frame_parser
// Finds 5-byte sync-header frames in a byte stream and checks their XOR sum.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received byte per transfer, in arrival order.
//   m_ channel: one transfer per completed frame. m_tuser carries the
//     checksum status (0 good, 1 mismatch); m_tdata carries the sequence
//     number and the good and bad frame counts after this frame.
//   APB port: register 0 (0x0) is the first sync byte, register 1 (0x4) the
//     second; both are read back on prdata.
// Throughput is one byte per cycle while no frame waits on a full result
// register, set by the position/XOR update between the input register and
// the result register. A frame's checksum byte, once taken on the s_ channel,
// goes to the input register, then to the result register behind m_tvalid.
// Reset (aresetn low, synchronous) empties both registers, returns the parser
// to sync hunting, zeroes the counters and loads the sync bytes 0xA5 / 0x5A.
// When the receiver stalls, a waiting result holds; bytes that give no result
// keep flowing, and the input stalls only when a frame ends with the result
// register still full.
// ----------------------------------------------------------------------------
module sync_header_frame_parser
    import shfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,     // [15:0] frame_seq, [47:16] good_frames,
                                     // [79:48] bad_frames
    output logic        m_tuser,     // [0] frame_status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;
    localparam logic              REG_SYNC_FIRST  = 1'b0;
    localparam logic              REG_SYNC_SECOND = 1'b1;

    logic [BYTE_W-1:0] sync_first_reg, sync_second_reg;
    logic              cfg_write;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              m_valid_reg, m_valid_next;
    shfp_result_t      m_result_reg;

    logic              frame_done;
    shfp_result_t      result;
    logic              out_free;
    logic              advance;
    logic              out_load;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_SYNC_FIRST:  sync_first_reg  <= pwdata[BYTE_W-1:0];
                REG_SYNC_SECOND: sync_second_reg <= pwdata[BYTE_W-1:0];
                default:         sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SYNC_SECOND: prdata = {24'd0, sync_second_reg};
            default:         prdata = {24'd0, sync_first_reg};
        endcase
    end

    // ---------------- datapath ----------------
    assign out_free = !m_valid_reg || m_tready;
    // only a frame-ending byte needs room in the result register
    assign advance  = in_valid_reg && (!frame_done || out_free);
    assign out_load = advance && frame_done;
    assign s_tready = !in_valid_reg || advance;

    shfp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .frame_done  (frame_done),
        .result      (result)
    );

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (out_load) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_result_reg.frame_status;
    assign m_tdata  = {m_result_reg.bad_frames, m_result_reg.good_frames,
                       m_result_reg.frame_seq};

`ifndef NO_ASSERTIONS
    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while full");

    // input backpressure only while a byte is held
    a_ready_low_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("s_tready low with empty input register");

    // a completed frame is presented on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("loaded result not presented");
`endif

endmodule

// ----- sv/shfp_core.sv -----
// ----------------------------------------------------------------------------
// shfp_core
// Frame position tracking, checksum accumulation and frame counters.
// ----------------------------------------------------------------------------
module shfp_core
    import shfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] sync_first,
    input  logic [BYTE_W-1:0] sync_second,
    output logic              frame_done,
    output shfp_result_t      result
);

    localparam logic [2:0] POS_IDLE   = 3'd0;
    localparam logic [2:0] POS_SYNC2  = 3'd1;
    localparam logic [2:0] POS_SEQ_HI = 3'd2;
    localparam logic [2:0] POS_SEQ_LO = 3'd3;
    localparam logic [2:0] POS_CSUM   = 3'd4;

    logic [2:0]         position_reg, position_next;
    logic [BYTE_W-1:0]  seq_high_reg, seq_high_next;
    logic [BYTE_W-1:0]  seq_low_reg, seq_low_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic [COUNT_W-1:0] good_reg, good_next;
    logic [COUNT_W-1:0] bad_reg, bad_next;
    logic               csum_bad;

    assign frame_done = (position_reg == POS_CSUM);
    assign csum_bad   = (rx_byte != xor_reg);

    always_comb begin
        position_next = position_reg;
        seq_high_next = seq_high_reg;
        seq_low_next  = seq_low_reg;
        xor_next      = xor_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        unique case (position_reg)
            POS_SYNC2: begin
                if (rx_byte == sync_second) begin
                    xor_next      = xor_reg ^ rx_byte;
                    position_next = POS_SEQ_HI;
                end else if (rx_byte == sync_first) begin
                    xor_next      = rx_byte;
                    position_next = POS_SYNC2;
                end else begin
                    xor_next      = '0;
                    position_next = POS_IDLE;
                end
            end
            POS_SEQ_HI: begin
                seq_high_next = rx_byte;
                xor_next      = xor_reg ^ rx_byte;
                position_next = POS_SEQ_LO;
            end
            POS_SEQ_LO: begin
                seq_low_next  = rx_byte;
                xor_next      = xor_reg ^ rx_byte;
                position_next = POS_CSUM;
            end
            POS_CSUM: begin
                if (csum_bad) begin
                    bad_next = bad_reg + COUNT_W'(1);
                end else begin
                    good_next = good_reg + COUNT_W'(1);
                end
                xor_next      = '0;
                position_next = POS_IDLE;
            end
            default: begin
                // hunt for the first sync byte; drop everything else
                if (rx_byte == sync_first) begin
                    xor_next      = rx_byte;
                    position_next = POS_SYNC2;
                end else begin
                    xor_next      = '0;
                    position_next = POS_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        result.frame_status = csum_bad;
        result.frame_seq    = {seq_high_reg, seq_low_reg};
        result.good_frames  = good_next;
        result.bad_frames   = bad_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= POS_IDLE;
            xor_reg      <= '0;
            good_reg     <= '0;
            bad_reg      <= '0;
        end else if (step) begin
            position_reg <= position_next;
            xor_reg      <= xor_next;
            good_reg     <= good_next;
            bad_reg      <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            seq_high_reg <= seq_high_next;
            seq_low_reg  <= seq_low_next;
        end
    end

endmodule
